/* sv/websocket_frame_deframer_unmask_defines.svh */
// Assertion macros for the websocket frame deframer.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef WEBSOCKET_FRAME_DEFRAMER_UNMASK_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_UNMASK_DEFINES_SVH

// same-cycle implication
`define WSDU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsdu assertion failed");

// next-cycle implication
`define WSDU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsdu assertion failed");

`endif

/* sv/wsdu_pkg.sv */
// Shared types and constants for the websocket frame deframer.
// No dependencies.
`default_nettype none

package wsdu_pkg;

	localparam int LENGTH_BITS = 64;
	localparam int LEN_W       = LENGTH_BITS;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [3:0] KEY_BYTES   = 4'd4;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_SHORT    = 2'd1;
	localparam status_t ST_UNMASKED = 2'd2;

	typedef enum logic [5:0] {
		PH_HDR0 = 6'b000001,
		PH_HDR1 = 6'b000010,
		PH_EXT  = 6'b000100,
		PH_MASK = 6'b001000,
		PH_PAY  = 6'b010000,
		PH_SKIP = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       has_byte;
		logic       frame_done;
		status_t    status;
		logic [3:0] opcode;
	} result_t;

endpackage

`default_nettype wire

/* sv/websocket_frame_deframer_unmask.sv */
// WebSocket frame deframer/unmasker top level; uses wsdu_pkg, wsdu_parser, wsdu_out_reg.
// Path: an accepted byte is captured in stage 1, then goes through the parser into the result register.
// Throughput: one byte per cycle, sustained, while res_ready stays high.
// Bytes that cause no result (header, trailing) leave the result register empty downstream.
// Reset: arst_n async low; parser returns to header byte 0, both stages empty.
`default_nettype none

module websocket_frame_deframer_unmask (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         rx_valid,
	output logic        rx_ready,
	input  wire  [7:0]  rx_byte,
	input  wire         buffer_end,
	output logic        res_valid,
	input  wire         res_ready,
	output logic [7:0]  payload_byte,
	output logic        has_byte,
	output logic        frame_done,
	output logic [1:0]  status,
	output logic [3:0]  opcode
);
	import wsdu_pkg::*;

	`include "websocket_frame_deframer_unmask_defines.svh"

	// stage 1: captured input byte
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	// advance: stage 1 request moves through the parser into the result reg
	logic        adv;
	logic        step_valid;
	result_t     step_res;
	result_t     res_s2;

	assign adv      = valid_s1 && (!res_valid || res_ready);
	assign rx_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
			end_s1  <= buffer_end;
		end
	end

	// header fsm, length/key registers and XOR unmask; state advances per request
	wsdu_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.rx_byte    (byte_s1),
		.buffer_end (end_s1),
		.res_valid  (step_valid),
		.res        (step_res)
	);

	// stage 2: result register facing the consumer
	wsdu_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (adv),
		.load_valid (step_valid),
		.load_res   (step_res),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.res_q      (res_s2)
	);

	assign payload_byte = res_s2.payload_byte;
	assign has_byte     = res_s2.has_byte;
	assign frame_done   = res_s2.frame_done;
	assign status       = res_s2.status;
	assign opcode       = res_s2.opcode;

	// error codes only ride on the done result
	`WSDU_ASSERT_IMPL(a_status_only_at_done, res_valid && !frame_done, status == ST_OK)
	// every shown result carries a byte or ends a frame
	`WSDU_ASSERT_IMPL(a_result_not_empty, res_valid, has_byte || frame_done)
	// an unmasked frame is rejected in the header, never with a payload byte
	`WSDU_ASSERT_IMPL(a_unmasked_no_byte, res_valid && status == ST_UNMASKED, !has_byte)
	// a done result from the parser lands in the result register
	`WSDU_ASSERT_NEXT(a_done_reaches_out, adv && step_valid && step_res.frame_done,
		res_valid && frame_done)

endmodule

`default_nettype wire

/* sv/wsdu_parser.sv */
// Header parser and payload unmasker: frame state plus one step of logic per byte.
// Depends on wsdu_pkg.
`default_nettype none

module wsdu_parser (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  wire  [7:0]           rx_byte,
	input  wire                  buffer_end,
	output logic                 res_valid,
	output wsdu_pkg::result_t    res
);
	import wsdu_pkg::*;

	phase_t            phase_q, phase_n;
	logic [3:0]        cnt_q, cnt_n;
	logic [LEN_W-1:0]  len_q, len_n;
	logic [31:0]       key_q, key_n;
	logic [1:0]        idx_q, idx_n;
	logic [3:0]        opc_q, opc_n;
	logic              mbit_q, mbit_n;
	logic [7:0]        key_byte;
	logic              done;
	status_t           st;
	logic [7:0]        pb;
	logic              hb;

	always_comb begin
		case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		key_n   = key_q;
		idx_n   = idx_q;
		opc_n   = opc_q;
		mbit_n  = mbit_q;
		done    = 1'b0;
		st      = ST_OK;
		pb      = 8'd0;
		hb      = 1'b0;
		case (phase_q)
			PH_HDR0: begin
				opc_n   = rx_byte[3:0];
				phase_n = PH_HDR1;
			end
			PH_HDR1: begin
				mbit_n = rx_byte[7];
				len_n  = '0;
				if (rx_byte[6:0] == LEN_EXT16) begin
					cnt_n   = EXT16_BYTES;
					phase_n = PH_EXT;
				end else if (rx_byte[6:0] == LEN_EXT64) begin
					cnt_n   = EXT64_BYTES;
					phase_n = PH_EXT;
				end else begin
					len_n = LEN_W'(rx_byte[6:0]);
					if (!rx_byte[7]) begin
						done = 1'b1;
						st   = ST_UNMASKED;
					end else begin
						phase_n = PH_MASK;
						cnt_n   = KEY_BYTES;
					end
				end
			end
			PH_EXT: begin
				// saturate once the top byte is occupied
				if (|len_q[LEN_W-1 -: 8])
					len_n = '1;
				else
					len_n = {len_q[LEN_W-9:0], rx_byte};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					if (!mbit_q) begin
						done = 1'b1;
						st   = ST_UNMASKED;
					end else begin
						phase_n = PH_MASK;
						cnt_n   = KEY_BYTES;
					end
				end
			end
			PH_MASK: begin
				key_n = {key_q[23:0], rx_byte};
				cnt_n = cnt_q - 4'd1;
				if (cnt_n == 4'd0) begin
					phase_n = PH_PAY;
					idx_n   = 2'd0;
					if (len_q == '0)
						done = 1'b1;
				end
			end
			PH_PAY: begin
				// len_q counts down the bytes still owed
				pb    = rx_byte ^ key_byte;
				hb    = 1'b1;
				idx_n = idx_q + 2'd1;
				len_n = len_q - LEN_W'(1);
				if (len_q == LEN_W'(1))
					done = 1'b1;
			end
			default: begin
			end
		endcase

		if (buffer_end && !done && phase_n != PH_SKIP) begin
			done = 1'b1;
			st   = ST_SHORT;
		end
		if (done)
			phase_n = PH_SKIP;

		res_valid        = hb | done;
		res.payload_byte = pb;
		res.has_byte     = hb;
		res.frame_done   = done;
		res.status       = st;
		res.opcode       = opc_n;

		if (buffer_end) begin
			phase_n = PH_HDR0;
			cnt_n   = 4'd0;
			len_n   = '0;
			key_n   = '0;
			idx_n   = 2'd0;
			opc_n   = 4'd0;
			mbit_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			cnt_q   <= 4'd0;
			len_q   <= '0;
			key_q   <= '0;
			idx_q   <= 2'd0;
			opc_q   <= 4'd0;
			mbit_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			key_q   <= key_n;
			idx_q   <= idx_n;
			opc_q   <= opc_n;
			mbit_q  <= mbit_n;
		end
	end

endmodule

`default_nettype wire

/* sv/wsdu_out_reg.sv */
// Result register stage of the deframer: holds one result until it is taken.
// Depends on wsdu_pkg.
`default_nettype none

module wsdu_out_reg (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  load,
	input  wire                  load_valid,
	input  wsdu_pkg::result_t    load_res,
	input  wire                  res_ready,
	output logic                 res_valid,
	output wsdu_pkg::result_t    res_q
);
	import wsdu_pkg::*;

	logic valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid)
			res_q <= load_res;
	end

	assign res_valid = valid_q;

endmodule

`default_nettype wire

/* verif/tb_websocket_frame_deframer_unmask.sv */
// Self-checking testbench for the websocket frame deframer/unmasker.
// Depends on wsdu_pkg and websocket_frame_deframer_unmask; a built-in predictor
// models header parsing, payload unmasking and status reporting.
module tb_websocket_frame_deframer_unmask;
	timeunit 1ns;
	timeprecision 1ps;

	import wsdu_pkg::*;

	localparam int CLK_PERIOD  = 4;
	localparam int RESET_CYCLES = 10;
	// slack after the last expected result, covering the drain at phase ends
	localparam int DRAIN_SLACK = 8;
	// watchdog bound on the whole run, with a wide margin over the slowest legal run
	localparam int CYCLE_LIMIT = 400_000;
	// largest legal length value; saturation target for oversized extended lengths
	localparam logic [63:0] LEN_ALL = {64{1'b1}} >> (64 - LENGTH_BITS);

	// how the payload length is encoded in header byte 1
	typedef enum int {LEN_SHORT, LEN_X16, LEN_X64} len_form_t;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       rx_valid   = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte    = 8'h00;
	logic       buffer_end = 1'b0;
	logic       res_valid;
	logic       res_ready  = 1'b0;
	logic [7:0] payload_byte;
	logic       has_byte;
	logic       frame_done;
	logic [1:0] status;
	logic [3:0] opcode;

	websocket_frame_deframer_unmask i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.buffer_end   (buffer_end),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.payload_byte (payload_byte),
		.has_byte     (has_byte),
		.frame_done   (frame_done),
		.status       (status),
		.opcode       (opcode)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Parser state of the predictor. Mirrors what the block must track
	// between bytes of one buffer.
	// ------------------------------------------------------------------
	phase_t      prs_phase;
	logic [3:0]  hdr_left;     // extended-length or key bytes still to come
	logic [63:0] frame_len;    // declared payload length
	logic [31:0] key_word;     // mask key, first key byte in the top byte
	logic [63:0] pay_seen;     // payload bytes unmasked so far
	logic [3:0]  cur_opcode;
	logic        mask_seen;

	// expected results, oldest first; filled as requests are accepted
	result_t frame_results_q[$];

	// bytes of the buffer being assembled for sending
	logic [7:0] tx_buf[$];

	// idling control: random gaps unless a no-idle stretch is on
	logic send_no_gaps   = 1'b0;
	logic recv_no_stalls = 1'b0;
	int   quiet_cycles   = 0;   // long receiver hold-off, counted down by the checker
	int   stall_left     = 0;

	// bookkeeping
	int fail_count      = 0;
	int bytes_sent      = 0;
	int buffers_sent    = 0;
	int results_checked = 0;
	int payload_checked = 0;
	int ends_by_status[3] = '{0, 0, 0};
	int cycle_count     = 0;

	function automatic void clear_parse();
		prs_phase  = PH_HDR0;
		hdr_left   = '0;
		frame_len  = '0;
		key_word   = '0;
		pay_seen   = '0;
		cur_opcode = '0;
		mask_seen  = 1'b0;
	endfunction

	// Length field is complete. An unmasked frame ends here with an error;
	// otherwise move on to the four key bytes.
	function automatic logic length_complete();
		if (!mask_seen)
			return 1'b1;
		prs_phase = PH_MASK;
		hdr_left  = KEY_BYTES;
		return 1'b0;
	endfunction

	// Predict what one accepted byte produces. Returns 1 if a result is due.
	function automatic logic deframe_step(input logic [7:0] b, input logic last,
			output result_t res);
		logic [6:0] len7;
		logic       done;
		status_t    st;
		res  = '0;
		done = 1'b0;
		st   = ST_OK;
		case (prs_phase)
			PH_HDR0: begin
				cur_opcode = b[3:0];
				prs_phase  = PH_HDR1;
			end
			PH_HDR1: begin
				mask_seen = b[7];
				len7      = b[6:0];
				frame_len = '0;
				if (len7 == LEN_EXT16) begin
					hdr_left  = EXT16_BYTES;
					prs_phase = PH_EXT;
				end else if (len7 == LEN_EXT64) begin
					hdr_left  = EXT64_BYTES;
					prs_phase = PH_EXT;
				end else begin
					frame_len = 64'(len7);
					if (length_complete()) begin
						done = 1'b1;
						st   = ST_UNMASKED;
					end
				end
			end
			PH_EXT: begin
				// big-endian accumulate, pinned at all ones once it would overflow
				if (frame_len > (LEN_ALL >> 8)) begin
					frame_len = LEN_ALL;
				end else begin
					frame_len = {frame_len[55:0], b};
					if (frame_len > LEN_ALL)
						frame_len = LEN_ALL;
				end
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0 && length_complete()) begin
					done = 1'b1;
					st   = ST_UNMASKED;
				end
			end
			PH_MASK: begin
				key_word = {key_word[23:0], b};
				hdr_left = hdr_left - 4'd1;
				if (hdr_left == 4'd0) begin
					prs_phase = PH_PAY;
					pay_seen  = '0;
					// empty payload: frame ends on the last key byte
					if (frame_len == '0) begin
						done = 1'b1;
						st   = ST_OK;
					end
				end
			end
			PH_PAY: begin
				res.payload_byte = b ^ key_word[8 * (3 - pay_seen[1:0]) +: 8];
				res.has_byte     = 1'b1;
				pay_seen         = pay_seen + 64'd1;
				if (pay_seen == frame_len) begin
					done = 1'b1;
					st   = ST_OK;
				end
			end
			default: ;   // trailing bytes after a finished frame
		endcase
		// buffer ran out before the frame was complete
		if (last && !done && prs_phase != PH_SKIP) begin
			done = 1'b1;
			st   = ST_SHORT;
		end
		if (done)
			prs_phase = PH_SKIP;
		res.frame_done = done;
		res.status     = st;
		res.opcode     = cur_opcode;
		if (last)
			clear_parse();
		return res.has_byte || done;
	endfunction

	// ------------------------------------------------------------------
	// Sender: one request per call. Valid stays up after acceptance so a
	// zero-gap follow-up keeps the stream back to back.
	// ------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b, input logic last);
		int      gap;
		result_t res;
		gap = send_no_gaps ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 15) : 0);
		if (gap != 0) begin
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_valid   <= 1'b1;
		rx_byte    <= b;
		buffer_end <= last;
		@(posedge clk);
		while (!rx_ready)
			@(posedge clk);
		if (deframe_step(b, last, res))
			frame_results_q.insert(frame_results_q.size(), res);
		bytes_sent++;
		if (last)
			buffers_sent++;
	endtask

	// send the first cut bytes of tx_buf as one buffer (all of it if cut <= 0)
	task automatic send_buffer(input int cut);
		int n;
		n = (cut <= 0 || cut > tx_buf.size()) ? tx_buf.size() : cut;
		for (int i = 0; i < n; i++)
			send_byte(tx_buf[i], i == n - 1);
		tx_buf.delete();
	endtask

	// drop valid and hold off until every expected result has come back
	task automatic wait_drained();
		rx_valid <= 1'b0;
		while (frame_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_SLACK) @(posedge clk);
	endtask

	// add one byte at the tail of the buffer being assembled
	function automatic void buf_add(input logic [7:0] b);
		tx_buf.insert(tx_buf.size(), b);
	endfunction

	// append one frame: header, optional key, body random payload bytes
	function automatic void add_frame(input logic [7:0] first, input logic masked,
			input len_form_t form, input logic [63:0] len, input logic [31:0] key,
			input int body);
		buf_add(first);
		case (form)
			LEN_SHORT: buf_add({masked, len[6:0]});
			LEN_X16: begin
				buf_add({masked, LEN_EXT16});
				buf_add(len[15:8]);
				buf_add(len[7:0]);
			end
			default: begin
				buf_add({masked, LEN_EXT64});
				for (int i = 7; i >= 0; i--)
					buf_add(len[8 * i +: 8]);
			end
		endcase
		if (masked)
			for (int i = 3; i >= 0; i--)
				buf_add(key[8 * i +: 8]);
		repeat (body) buf_add(8'($urandom));
	endfunction

	// One buffer holding a mostly well-formed frame with random content.
	// Large declared lengths get a short body, so the buffer ends early.
	task automatic random_frame();
		logic [63:0] len;
		len_form_t   form;
		int          pick;
		int          body;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			form = LEN_SHORT;
			len  = 64'($urandom_range(0, 12));
		end else if (pick < 75) begin
			form = LEN_SHORT;
			len  = 64'($urandom_range(0, 125));
		end else if (pick < 88) begin
			form = LEN_X16;
			len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
				: 64'($urandom_range(0, 40));
		end else begin
			form = LEN_X64;
			len  = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
				: 64'($urandom_range(0, 40));
		end
		body = (len > 64'd48) ? int'($urandom_range(0, 48)) : int'(len);
		add_frame(8'($urandom), $urandom_range(0, 9) != 0, form, len, $urandom, body);
		// trailing junk after the frame
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 4)) buf_add(8'($urandom));
		// now and then cut the buffer anywhere
		send_buffer(($urandom_range(0, 9) == 0) ? $urandom_range(1, tx_buf.size()) : 0);
	endtask

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------

	// Hand-picked buffers for each way a frame can end.
	task automatic test_header_corner_cases();
		// buffer of a single byte: short, opcode still reported
		tx_buf = '{8'hFF};
		send_buffer(0);
		// unmasked frame ends at byte 1; the trailing byte is ignored
		tx_buf = '{8'h00, 8'h05, 8'hAA};
		send_buffer(0);
		// buffer ends inside the 16-bit length: short even though unmasked
		tx_buf = '{8'h81, 8'h7E, 8'h01};
		send_buffer(0);
		// empty masked payload: done on the last key byte
		tx_buf = '{8'h8A, 8'h80, 8'h12, 8'h34, 8'h56, 8'h78};
		send_buffer(0);
		// 16-bit length 3, only two payload bytes: last byte carries the short status
		tx_buf = '{8'h82, 8'hFE, 8'h00, 8'h03, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
		send_buffer(0);
		wait_drained();
	endtask

	// Bulk of the run: well-formed frames with random content and idling,
	// with occasional stretches where neither side idles.
	task automatic test_wellformed_frames(input int n_bytes);
		int stop;
		stop = bytes_sent + n_bytes;
		while (bytes_sent < stop) begin
			send_no_gaps   = ($urandom_range(0, 5) == 0);
			recv_no_stalls = ($urandom_range(0, 5) == 0);
			random_frame();
		end
		send_no_gaps   = 1'b0;
		recv_no_stalls = 1'b0;
	endtask

	// Random bytes with random buffer ends.
	task automatic test_line_noise(input int n_bytes);
		for (int i = 0; i < n_bytes; i++)
			send_byte(8'($urandom), i == n_bytes - 1 || $urandom_range(0, 5) == 0);
	endtask

	// Receiver goes quiet for a long time while a long frame streams in
	// back to back; the block has to fill up and push back on rx_ready.
	task automatic test_output_backpressure();
		quiet_cycles = 300;
		send_no_gaps = 1'b1;
		add_frame(8'h82, 1'b1, LEN_SHORT, 64'd120, $urandom, 120);
		send_buffer(0);
		send_no_gaps = 1'b0;
		wait_drained();
	endtask

	// Sender stops after each buffer until all its results are back.
	task automatic test_pause_until_drained(input int n_buffers);
		repeat (n_buffers) begin
			random_frame();
			wait_drained();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls per result, long hold-off on request,
	// and the field-by-field check of every accepted result.
	// ------------------------------------------------------------------
	function automatic void compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	result_t want_res;

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (frame_results_q.size() == 0) begin
				$error("unexpected result: payload_byte %0h has_byte %0b frame_done %0b status %0d",
					payload_byte, has_byte, frame_done, status);
				fail_count++;
			end else begin
				want_res = frame_results_q.pop_front();
				compare_field("payload_byte", want_res.payload_byte, payload_byte);
				compare_field("has_byte", 8'(want_res.has_byte), 8'(has_byte));
				compare_field("frame_done", 8'(want_res.frame_done), 8'(frame_done));
				compare_field("status", 8'(want_res.status), 8'(status));
				compare_field("opcode", 8'(want_res.opcode), 8'(opcode));
				results_checked++;
				if (want_res.has_byte)
					payload_checked++;
				if (want_res.frame_done)
					ends_by_status[want_res.status]++;
			end
			stall_left = recv_no_stalls ? 0
				: (($urandom_range(0, 1) == 0) ? $urandom_range(0, 15) : 0);
		end
		if (quiet_cycles > 0) begin
			quiet_cycles--;
			res_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding",
				cycle_count, frame_results_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clear_parse();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_corner_cases();
		test_wellformed_frames(1000);
		test_line_noise(150);
		test_output_backpressure();
		test_pause_until_drained(6);

		wait_drained();
		$display("Sent %0d bytes in %0d buffers; checked %0d results, %0d of them payload bytes.",
			bytes_sent, buffers_sent, results_checked, payload_checked);
		$display("Frame ends seen: %0d ok, %0d short buffer, %0d unmasked.",
			ends_by_status[0], ends_by_status[1], ends_by_status[2]);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
